// ----- hdl/assert_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// ----- hdl/drbs_pkg.sv -----
// package with codes, widths and control types of the dense rank block
`timescale 1ns / 1ps

package drbs_pkg;

	localparam int MODE_W   = 2;
	localparam int RANK_W   = 11;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_APPEND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PROBE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic probe;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_search;
		logic more;
		logic slot_free;
	} stat_t;

endpackage

// ----- hdl/drbs_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module drbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/drbs_ctrl.sv -----
// controller state machine sequencing accept, execute, search and output
`timescale 1ns / 1ps

module drbs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  drbs_pkg::stat_t stat,
	output drbs_pkg::cmd_t  cmd
);

	import drbs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_search ? ST_PROBE : ST_DONE;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				if (!stat.more) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.slot_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/drbs_dp.sv -----
// datapath: table ram, append bookkeeping, binary search and output register
`timescale 1ns / 1ps

module drbs_dp #(
	parameter int TABLE_DEPTH = 1024,
	parameter int SCORE_BITS  = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  drbs_pkg::cmd_t                cmd,
	output drbs_pkg::stat_t               stat,
	input  logic [drbs_pkg::MODE_W-1:0]   mode,
	input  logic [SCORE_BITS-1:0]         score_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [drbs_pkg::RANK_W-1:0]   rank,
	output logic [drbs_pkg::STATUS_W-1:0] status
);

	import drbs_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int DW = SCORE_BITS + RANK_W;

	logic [MODE_W-1:0]     mode_q;
	logic [SCORE_BITS-1:0] score_q;
	logic [CW-1:0]         count_q;
	logic [SCORE_BITS-1:0] last_score_q;
	logic [RANK_W-1:0]     last_rank_q;
	logic [AW-1:0]         lo_q;
	logic [AW-1:0]         hi_q;
	logic [AW-1:0]         mid_q;
	logic [RANK_W-1:0]     res_rank_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  out_valid_q;
	logic [RANK_W-1:0]     rank_q;
	logic [STATUS_W-1:0]   status_q;

	logic                  full;
	logic                  empty;
	logic                  need_search;
	logic                  more;
	logic                  le;
	logic [AW-1:0]         hi0;
	logic [AW-1:0]         mid0;
	logic [AW-1:0]         lo_n;
	logic [AW-1:0]         hi_n;
	logic [AW:0]           sum_n;
	logic [AW-1:0]         mid_n;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [DW-1:0]         rd_data;
	logic [SCORE_BITS-1:0] rd_score;
	logic [RANK_W-1:0]     rd_rank;
	logic                  wr_en;
	logic [RANK_W-1:0]     app_rank;

	assign full        = (count_q == CW'(TABLE_DEPTH));
	assign empty       = (count_q == '0);
	assign need_search = (mode_q == MODE_QUERY) && !empty;
	assign more        = (lo_q < hi_q);

	assign hi0  = AW'(count_q - 1'b1);
	assign mid0 = hi0 >> 1;

	assign rd_score = rd_data[DW-1:RANK_W];
	assign rd_rank  = rd_data[RANK_W-1:0];
	assign le       = (rd_score <= score_q);

	always_comb begin
		if (le) begin
			lo_n = lo_q;
			hi_n = mid_q;
		end else begin
			lo_n = mid_q + AW'(1);
			hi_n = hi_q;
		end
	end

	assign sum_n = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n = sum_n[AW:1];

	assign rd_en   = (cmd.exec && need_search) || (cmd.probe && more);
	assign rd_addr = cmd.exec ? mid0 : mid_n;

	always_comb begin
		if (empty) begin
			app_rank = RANK_W'(1);
		end else if (score_q < last_score_q) begin
			app_rank = last_rank_q + RANK_W'(1);
		end else begin
			app_rank = last_rank_q;
		end
	end

	assign wr_en = cmd.exec && (mode_q == MODE_APPEND) && !full
		&& (empty || (score_q <= last_score_q));

	drbs_ram #(
		.WIDTH (DW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data ({score_q, app_rank}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			score_q <= score_value;
		end
		if (cmd.exec) begin
			lo_q  <= '0;
			hi_q  <= hi0;
			mid_q <= mid0;
			case (mode_q)
				MODE_APPEND: begin
					if (full) begin
						res_rank_q   <= '0;
						res_status_q <= STATUS_FULL;
					end else if (!empty && (score_q > last_score_q)) begin
						res_rank_q   <= '0;
						res_status_q <= STATUS_ORDER;
					end else begin
						res_rank_q   <= app_rank;
						res_status_q <= STATUS_OK;
					end
				end
				MODE_QUERY: begin
					res_rank_q   <= RANK_W'(1);
					res_status_q <= STATUS_OK;
				end
				default: begin
					res_rank_q   <= '0;
					res_status_q <= STATUS_OK;
				end
			endcase
		end
		if (cmd.probe) begin
			if (more) begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
			end else begin
				res_rank_q   <= le ? rd_rank : rd_rank + RANK_W'(1);
				res_status_q <= STATUS_OK;
			end
		end
		if (cmd.emit) begin
			rank_q   <= res_rank_q;
			status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			last_score_q <= '0;
			last_rank_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.exec && (mode_q == MODE_CLEAR)) begin
				count_q      <= '0;
				last_score_q <= '0;
				last_rank_q  <= '0;
			end else if (wr_en) begin
				count_q      <= count_q + CW'(1);
				last_score_q <= score_q;
				last_rank_q  <= app_rank;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.need_search = need_search;
	assign stat.more        = more;
	assign stat.slot_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign rank      = rank_q;
	assign status    = status_q;

endmodule

// ----- hdl/dense_rank_binary_search.sv -----
// top level of the dense rank table with binary-search lookup
//
// input channel in_valid/in_ready carries mode and score_value; mode clear
// empties the table, append adds a score (non-increasing order), query
// returns the dense rank of a score. every item gives one result on the
// out_valid/out_ready channel with rank and status.
// items are worked one at a time: in_ready is high only while the block is
// idle. clear, append and unused mode go from accept through the execute
// step to the done step; a query on a non-empty table also passes through
// the search loop, which makes one probe per cycle through the single
// registered read port of the table ram.
// the result sits in an output register; when the receiver stalls it holds
// there with its payload unchanged and the next item waits in the done step.
// reset clears the entry count, the newest score and rank and the output
// valid; table ram contents are left as they are and only entries below
// the count are ever read, so no clearing pass is needed.
`timescale 1ns / 1ps

module dense_rank_binary_search #(
	parameter int TABLE_DEPTH = 1024,
	parameter int SCORE_BITS  = 31
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [drbs_pkg::MODE_W-1:0]   mode,
	input  logic [SCORE_BITS-1:0]         score_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [drbs_pkg::RANK_W-1:0]   rank,
	output logic [drbs_pkg::STATUS_W-1:0] status
);

	import drbs_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	drbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	drbs_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.SCORE_BITS  (SCORE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.mode        (mode),
		.score_value (score_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.rank        (rank),
		.status      (status)
	);

endmodule

// ----- hdl/drbs_checker.sv -----
// port-level checker for the dense rank block and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module drbs_checker #(
	parameter int SCORE_BITS = 31
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [drbs_pkg::MODE_W-1:0]   mode,
	input logic [SCORE_BITS-1:0]         score_value,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [drbs_pkg::RANK_W-1:0]   rank,
	input logic [drbs_pkg::STATUS_W-1:0] status
);

	import drbs_pkg::*;

	logic in_wait;

	assign in_wait = in_valid && !in_ready;

	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(rank) && $stable(status))
	`ASSERT_NXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)
	`ASSERT_IMP(a_reject_rank, clk, arst_n, out_valid && (status != STATUS_OK), rank == '0)
	`ASSERT_IMP(a_status_code, clk, arst_n, out_valid, status <= STATUS_ORDER)
	`ASSERT_NXT(a_in_hold, clk, arst_n, in_wait, in_valid && $stable(mode) && $stable(score_value))

endmodule

bind dense_rank_binary_search drbs_checker #(
	.SCORE_BITS (SCORE_BITS)
) u_drbs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.mode        (mode),
	.score_value (score_value),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.rank        (rank),
	.status      (status)
);
